// ===== design/tft_pkg.sv =====
// Shared types for the triangle face tangent block.
package tft_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_DABS,
        S_NABS,
        S_DCHK,
        S_DIV,
        S_ROUND,
        S_FIN,
        S_OUT
    } t_state;

endpackage

// ===== design/tft_vtx_if.sv =====
// Vertex channel: position and texture coordinate with valid/ready.
interface tft_vtx_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
    logic signed [COORD_WIDTH-1:0] tex_u;
    logic signed [COORD_WIDTH-1:0] tex_v;

    modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

// ===== design/tft_tan_if.sv =====
// Tangent channel: one corner tangent with flags, valid/ready.
interface tft_tan_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] tangent_x;
    logic signed [COORD_WIDTH-1:0] tangent_y;
    logic signed [COORD_WIDTH-1:0] tangent_z;
    logic                          degenerate;
    logic                          last_corner;

    modport source (output valid, tangent_x, tangent_y, tangent_z, degenerate, last_corner,
                    input ready);
    modport sink   (input valid, tangent_x, tangent_y, tangent_z, degenerate, last_corner,
                    output ready);
endinterface

// ===== design/tft_alu.sv =====
// Shared add/subtract unit with carry out, used for multiply, divide and negate steps.
module tft_alu #(
    parameter int WIDTH = 66
) (
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    input  logic             i_sub,
    output logic [WIDTH-1:0] o_sum,
    output logic             o_carry
);
    logic [WIDTH-1:0] w_b;

    assign w_b = i_sub ? ~i_b : i_b;

    // With i_sub set, o_carry is high when i_a >= i_b taken as unsigned.
    assign {o_carry, o_sum} = {1'b0, i_a} + {1'b0, w_b} + {{WIDTH{1'b0}}, i_sub};
endmodule

// ===== design/triangle_face_tangent.sv =====
// Top level: per-face tangent from a stream of textured vertices.
//
//  channel  dir  word                                          handshake
//  i_vtx    in   pos_x, pos_y, pos_z, tex_u, tex_v             valid/ready
//  o_tan    out  tangent_x/y/z, degenerate, last_corner        valid/ready
//
// The first two vertices of a triangle are stored as they are taken. The third
// starts a sequence on one shared add/subtract unit: two signed shift-add products
// per determinant and per numerator (COORD_WIDTH+1 steps each) and one restoring
// divide per axis (COORD_WIDTH+1 steps); the sequence is shorter when the
// determinant is zero or a quotient saturates early. Three words are then
// offered; vertices of the next triangle's first two corners are taken while
// they drain. Reset is synchronous, active low, and clears the corner count and
// sequencer; a stalled output word holds.
module triangle_face_tangent #(
    parameter int COORD_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tft_vtx_if.sink   i_vtx,
    tft_tan_if.source o_tan
);
    localparam int W  = COORD_WIDTH;
    localparam int F  = FRACTION_BITS;
    localparam int PW = 2 * W + 2;
    localparam int MW = 2 * W + 1;
    localparam int RW = 2 * W + 1;
    localparam int NW = MW + F;
    localparam int SW = $clog2(W + 1);
    localparam int UW = (W + F > 2 * W + 2) ? W + F : 2 * W + 2;

    tft_pkg::t_state r_state, n_state;

    logic [W-1:0]  r_p0 [3];
    logic [W-1:0]  r_p1 [3];
    logic [W-1:0]  r_t0 [2];
    logic [W-1:0]  r_t1 [2];
    logic [1:0]    r_cnt;
    logic [1:0]    r_emit;

    logic [W:0]    r_dv1, r_dv2, r_du2;
    logic [W:0]    r_e1 [3];
    logic [W:0]    r_e2 [3];
    logic [PW-1:0] r_acc, r_mc;
    logic [W:0]    r_mp;
    logic [SW-1:0] r_step;
    logic          r_term, r_det_ph;
    logic [1:0]    r_axis;
    logic [MW-1:0] r_dmag, r_nmag;
    logic          r_dneg, r_qneg, r_degen;
    logic [RW-1:0] r_rem;
    logic [W:0]    r_nlo;
    logic [W+1:0]  r_q;
    logic [W-1:0]  r_tan [3];

    logic          vtx_fire, tan_fire, step_last;
    logic [W-1:0]  w_pin [3];
    logic [W:0]    w_du1, w_dv1, w_du2, w_dv2;
    logic [W:0]    w_mc1_src;
    logic [NW-1:0] w_nfull;
    logic [W+F-1:0] w_rem0;
    logic [W:0]    w_nlo0;
    logic [UW-1:0] alu_a, alu_b, alu_sum;
    logic          alu_sub, alu_carry;
    logic [MW-1:0] w_absval;
    logic [W-1:0]  w_limit, w_mag, w_tval;
    logic [1:0]    w_axis_nx;

    tft_alu #(.WIDTH(UW)) u_alu (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_sub   (alu_sub),
        .o_sum   (alu_sum),
        .o_carry (alu_carry)
    );

    assign vtx_fire  = i_vtx.valid && i_vtx.ready;
    assign tan_fire  = o_tan.valid && o_tan.ready;
    assign step_last = (r_step == SW'(W));

    assign w_pin[0] = i_vtx.pos_x;
    assign w_pin[1] = i_vtx.pos_y;
    assign w_pin[2] = i_vtx.pos_z;

    assign w_du1 = {r_t1[0][W-1], r_t1[0]} - {r_t0[0][W-1], r_t0[0]};
    assign w_dv1 = {r_t1[1][W-1], r_t1[1]} - {r_t0[1][W-1], r_t0[1]};
    assign w_du2 = {i_vtx.tex_u[W-1], i_vtx.tex_u} - {r_t0[0][W-1], r_t0[0]};
    assign w_dv2 = {i_vtx.tex_v[W-1], i_vtx.tex_v} - {r_t0[1][W-1], r_t0[1]};

    // The second product term is always something times dV1.
    assign w_mc1_src = r_det_ph ? r_du2 : r_e2[r_axis];

    // Scaled numerator magnitude, split into the part that seeds the remainder
    // and the low bits that are shifted in one per divide step.
    assign w_nfull = {r_nmag, {F{1'b0}}};
    assign w_rem0  = w_nfull[NW-1:W+1];
    assign w_nlo0  = w_nfull[W:0];

    assign w_absval  = r_acc[PW-1] ? alu_sum[MW-1:0] : r_acc[MW-1:0];
    assign w_axis_nx = r_axis + 2'd1;

    assign w_limit = r_qneg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    assign w_mag   = (r_q > {2'b00, w_limit}) ? w_limit : r_q[W-1:0];
    assign w_tval  = r_qneg ? (~w_mag + {{(W-1){1'b0}}, 1'b1}) : w_mag;

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (r_state) inside
            tft_pkg::S_MUL: begin
                alu_a   = UW'(r_acc);
                alu_b   = r_mp[0] ? UW'(r_mc) : '0;
                // The multiplier's sign bit carries negative weight.
                alu_sub = r_term ^ step_last;
            end
            tft_pkg::S_DABS, tft_pkg::S_NABS: begin
                alu_b   = UW'(r_acc);
                alu_sub = 1'b1;
            end
            tft_pkg::S_DCHK: begin
                alu_a   = UW'(w_rem0);
                alu_b   = UW'(r_dmag);
                alu_sub = 1'b1;
            end
            tft_pkg::S_DIV: begin
                alu_a   = UW'({r_rem, r_nlo[W]});
                alu_b   = UW'(r_dmag);
                alu_sub = 1'b1;
            end
            tft_pkg::S_ROUND: begin
                alu_a   = UW'({r_rem, 1'b0});
                alu_b   = UW'(r_dmag);
                alu_sub = 1'b1;
            end
            default: begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tft_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        i_vtx.ready = 1'b0;
        o_tan.valid = 1'b0;
        unique case (r_state)
            tft_pkg::S_IDLE: begin
                i_vtx.ready = 1'b1;
                if (vtx_fire && r_cnt[1]) begin
                    n_state = tft_pkg::S_MUL;
                end
            end
            tft_pkg::S_MUL: begin
                if (step_last && r_term) begin
                    n_state = r_det_ph ? tft_pkg::S_DABS : tft_pkg::S_NABS;
                end
            end
            tft_pkg::S_DABS: begin
                n_state = (r_acc == '0) ? tft_pkg::S_OUT : tft_pkg::S_MUL;
            end
            tft_pkg::S_NABS: begin
                n_state = tft_pkg::S_DCHK;
            end
            tft_pkg::S_DCHK: begin
                n_state = alu_carry ? tft_pkg::S_FIN : tft_pkg::S_DIV;
            end
            tft_pkg::S_DIV: begin
                if (step_last) begin
                    n_state = tft_pkg::S_ROUND;
                end
            end
            tft_pkg::S_ROUND: begin
                n_state = tft_pkg::S_FIN;
            end
            tft_pkg::S_FIN: begin
                n_state = (r_axis == 2'd2) ? tft_pkg::S_OUT : tft_pkg::S_MUL;
            end
            tft_pkg::S_OUT: begin
                o_tan.valid = 1'b1;
                i_vtx.ready = !r_cnt[1];
                if (tan_fire && r_emit == 2'd2) begin
                    n_state = tft_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tft_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_emit <= 2'd0;
        end else begin
            if (vtx_fire) begin
                r_cnt <= r_cnt[1] ? 2'd0 : r_cnt + 2'd1;
            end
            if (r_state == tft_pkg::S_DABS || r_state == tft_pkg::S_FIN) begin
                r_emit <= 2'd0;
            end else if (tan_fire) begin
                r_emit <= r_emit + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (vtx_fire) begin
            case (r_cnt)
                2'd0: begin
                    r_p0    <= w_pin;
                    r_t0[0] <= i_vtx.tex_u;
                    r_t0[1] <= i_vtx.tex_v;
                end
                2'd1: begin
                    r_p1    <= w_pin;
                    r_t1[0] <= i_vtx.tex_u;
                    r_t1[1] <= i_vtx.tex_v;
                end
                default: begin
                    for (int k = 0; k < 3; k++) begin
                        r_e1[k] <= {r_p1[k][W-1], r_p1[k]} - {r_p0[k][W-1], r_p0[k]};
                        r_e2[k] <= {w_pin[k][W-1], w_pin[k]} - {r_p0[k][W-1], r_p0[k]};
                    end
                    r_dv1    <= w_dv1;
                    r_dv2    <= w_dv2;
                    r_du2    <= w_du2;
                    r_acc    <= '0;
                    r_mc     <= {{(PW-W-1){w_du1[W]}}, w_du1};
                    r_mp     <= w_dv2;
                    r_step   <= '0;
                    r_term   <= 1'b0;
                    r_det_ph <= 1'b1;
                end
            endcase
        end

        case (r_state)
            tft_pkg::S_MUL: begin
                r_acc <= alu_sum[PW-1:0];
                if (!step_last) begin
                    r_mc   <= {r_mc[PW-2:0], 1'b0};
                    r_mp   <= {1'b0, r_mp[W:1]};
                    r_step <= r_step + SW'(1);
                end else begin
                    r_step <= '0;
                    if (!r_term) begin
                        r_term <= 1'b1;
                        r_mc   <= {{(PW-W-1){w_mc1_src[W]}}, w_mc1_src};
                        r_mp   <= r_dv1;
                    end
                end
            end
            tft_pkg::S_DABS: begin
                r_dneg  <= r_acc[PW-1];
                r_dmag  <= w_absval;
                r_degen <= (r_acc == '0);
                if (r_acc == '0) begin
                    for (int k = 0; k < 3; k++) begin
                        r_tan[k] <= '0;
                    end
                end else begin
                    r_acc    <= '0;
                    r_mc     <= {{(PW-W-1){r_e1[0][W]}}, r_e1[0]};
                    r_mp     <= r_dv2;
                    r_term   <= 1'b0;
                    r_det_ph <= 1'b0;
                    r_axis   <= 2'd0;
                    r_step   <= '0;
                end
            end
            tft_pkg::S_NABS: begin
                r_nmag <= w_absval;
                r_qneg <= r_acc[PW-1] ^ r_dneg;
            end
            tft_pkg::S_DCHK: begin
                if (alu_carry) begin
                    // Quotient is at least 2^(W+1): mark it past any limit.
                    r_q <= {1'b1, {(W+1){1'b0}}};
                end else begin
                    r_rem  <= RW'(w_rem0);
                    r_nlo  <= w_nlo0;
                    r_q    <= '0;
                    r_step <= '0;
                end
            end
            tft_pkg::S_DIV: begin
                r_rem  <= alu_carry ? alu_sum[RW-1:0] : {r_rem[RW-2:0], r_nlo[W]};
                r_q    <= {r_q[W:0], alu_carry};
                r_nlo  <= {r_nlo[W-1:0], 1'b0};
                r_step <= r_step + SW'(1);
            end
            tft_pkg::S_ROUND: begin
                // Round half away from zero on the magnitude.
                r_q <= r_q + {{(W+1){1'b0}}, alu_carry};
            end
            tft_pkg::S_FIN: begin
                r_tan[r_axis] <= w_tval;
                if (r_axis != 2'd2) begin
                    r_axis <= w_axis_nx;
                    r_acc  <= '0;
                    r_mc   <= {{(PW-W-1){r_e1[w_axis_nx][W]}}, r_e1[w_axis_nx]};
                    r_mp   <= r_dv2;
                    r_term <= 1'b0;
                    r_step <= '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_tan.tangent_x   = r_tan[0];
    assign o_tan.tangent_y   = r_tan[1];
    assign o_tan.tangent_z   = r_tan[2];
    assign o_tan.degenerate  = r_degen;
    assign o_tan.last_corner = (r_emit == 2'd2);
endmodule

// ===== tb/sv/triangle_face_tangent_tb.sv =====
// Self-checking testbench for the triangle face tangent block.
module triangle_face_tangent_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;
    localparam int DRAIN_CYCLES  = 11 * COORD_WIDTH + 60;
    localparam int TRI_PER_PHASE = 36;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    localparam t_coord COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam t_coord COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam t_coord COORD_ONE = t_coord'(1) <<< FRACTION_BITS;

    typedef struct packed {
        t_coord pos_x;
        t_coord pos_y;
        t_coord pos_z;
        t_coord tex_u;
        t_coord tex_v;
    } t_vertex;

    typedef struct packed {
        t_coord tangent_x;
        t_coord tangent_y;
        t_coord tangent_z;
        logic   degenerate;
        logic   last_corner;
    } t_tangent;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tft_vtx_if #(.COORD_WIDTH(COORD_WIDTH)) vtx ();
    tft_tan_if #(.COORD_WIDTH(COORD_WIDTH)) tan ();

    triangle_face_tangent #(
        .COORD_WIDTH  (COORD_WIDTH),
        .FRACTION_BITS(FRACTION_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vtx  (vtx),
        .o_tan  (tan)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    int unsigned source_idle_pct = 0;
    int unsigned sink_idle_pct   = 0;
    int unsigned mismatches      = 0;

    // Predictor state: corner slot and the two stored corners of the open triangle.
    logic [1:0]  corner_slot = 2'd0;
    t_vertex     corner_a;
    t_vertex     corner_b;
    t_tangent    expected_tangents[$];

    // Rounded (ties away from zero) and saturated num * 2^FRACTION_BITS / det.
    function automatic t_coord divide_round_sat(input logic signed [127:0] num,
                                                input logic signed [127:0] det);
        logic         neg;
        logic [127:0] n;
        logic [127:0] d;
        logic [127:0] q;
        logic [127:0] r;
        logic [127:0] lim;
        neg = num[127] ^ det[127];
        n   = num[127] ? -num : num;
        d   = det[127] ? -det : det;
        n   = n << FRACTION_BITS;
        q   = n / d;
        r   = n % d;
        if ((r << 1) >= d)
            q = q + 128'd1;
        lim = (128'd1 << (COORD_WIDTH - 1)) - (neg ? 128'd0 : 128'd1);
        if (q > lim)
            q = lim;
        if (neg)
            q = -q;
        return q[COORD_WIDTH-1:0];
    endfunction

    task automatic predict_tangents(input t_vertex v);
        logic signed [127:0] du1, dv1, du2, dv2, det, e1, e2, num;
        t_coord              pa[3];
        t_coord              pb[3];
        t_coord              pc[3];
        t_coord              axis[3];
        logic                degen;
        t_tangent            word;
        if (corner_slot == 2'd0) begin
            corner_a    = v;
            corner_slot = 2'd1;
        end else if (corner_slot == 2'd1) begin
            corner_b    = v;
            corner_slot = 2'd2;
        end else begin
            corner_slot = 2'd0;
            du1   = $signed(corner_b.tex_u) - $signed(corner_a.tex_u);
            dv1   = $signed(corner_b.tex_v) - $signed(corner_a.tex_v);
            du2   = $signed(v.tex_u) - $signed(corner_a.tex_u);
            dv2   = $signed(v.tex_v) - $signed(corner_a.tex_v);
            det   = du1 * dv2 - du2 * dv1;
            degen = (det == 0);
            pa    = '{corner_a.pos_x, corner_a.pos_y, corner_a.pos_z};
            pb    = '{corner_b.pos_x, corner_b.pos_y, corner_b.pos_z};
            pc    = '{v.pos_x, v.pos_y, v.pos_z};
            for (int i = 0; i < 3; i++) begin
                e1      = pb[i] - pa[i];
                e2      = pc[i] - pa[i];
                num     = dv2 * e1 - dv1 * e2;
                axis[i] = degen ? t_coord'(0) : divide_round_sat(num, det);
            end
            for (int k = 0; k < 3; k++) begin
                word = '{axis[0], axis[1], axis[2], degen, (k == 2)};
                expected_tangents.push_back(word);
            end
        end
    endtask

    // Offers one vertex word and holds it until the block takes it.
    task automatic send_vertex(input t_vertex v);
        while ($urandom_range(99) < source_idle_pct) begin
            vtx.valid <= 1'b0;
            @(posedge i_clk);
        end
        vtx.valid <= 1'b1;
        vtx.pos_x <= v.pos_x;
        vtx.pos_y <= v.pos_y;
        vtx.pos_z <= v.pos_z;
        vtx.tex_u <= v.tex_u;
        vtx.tex_v <= v.tex_v;
        do @(posedge i_clk); while (!vtx.ready);
        predict_tangents(v);
    endtask

    function automatic t_vertex make_vertex(input t_coord px, input t_coord py,
                                            input t_coord pz, input t_coord u,
                                            input t_coord v);
        return '{px, py, pz, u, v};
    endfunction

    // Flavor 0: extreme codes, 1: full range, otherwise small values near the origin.
    function automatic t_coord pick_coord(input int unsigned flavor);
        case (flavor)
            0: begin
                case ($urandom_range(4))
                    0:       return COORD_MIN;
                    1:       return COORD_MAX;
                    2:       return t_coord'(0);
                    3:       return t_coord'(-1);
                    default: return t_coord'(1);
                endcase
            end
            1:       return t_coord'($urandom());
            default: return t_coord'($urandom_range(0, 32'h000F_FFFF)) - t_coord'(32'h0008_0000);
        endcase
    endfunction

    function automatic t_vertex random_vertex(input int unsigned kind);
        t_vertex v;
        v.pos_x = pick_coord(kind == 2 ? $urandom_range(2) : kind);
        v.pos_y = pick_coord(kind == 2 ? $urandom_range(2) : kind);
        v.pos_z = pick_coord(kind == 2 ? $urandom_range(2) : kind);
        v.tex_u = pick_coord(kind == 2 ? $urandom_range(2) : kind);
        v.tex_v = pick_coord(kind == 2 ? $urandom_range(2) : kind);
        return v;
    endfunction

    task automatic test_unit_triangle();
        send_vertex(make_vertex(0, 0, 0, 0, 0));
        send_vertex(make_vertex(COORD_ONE, 0, 0, COORD_ONE, 0));
        send_vertex(make_vertex(0, COORD_ONE, 0, 0, COORD_ONE));
    endtask

    task automatic test_degenerate_uv();
        // All three corners share one texture coordinate.
        send_vertex(make_vertex(1, 2, 3, COORD_ONE, COORD_ONE));
        send_vertex(make_vertex(COORD_MAX, 0, COORD_MIN, COORD_ONE, COORD_ONE));
        send_vertex(make_vertex(COORD_MIN, COORD_MAX, 7, COORD_ONE, COORD_ONE));
        // Texture coordinates on one line.
        send_vertex(make_vertex(0, 0, 0, 0, 0));
        send_vertex(make_vertex(COORD_ONE, 5, 0, COORD_ONE, 2 * COORD_ONE));
        send_vertex(make_vertex(-COORD_ONE, 0, 9, 3 * COORD_ONE, 6 * COORD_ONE));
    endtask

    task automatic test_saturation_and_extremes();
        // A determinant of one LSB squared drives the quotient far past both rails.
        send_vertex(make_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 0, 0));
        send_vertex(make_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1, 0));
        send_vertex(make_vertex(0, 0, 0, 0, 1));
        send_vertex(make_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 0, 0));
        send_vertex(make_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1, 0));
        send_vertex(make_vertex(COORD_MAX, COORD_MIN, 0, 0, 1));
        // Every field at its extremes at once.
        send_vertex(make_vertex(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        send_vertex(make_vertex(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
        send_vertex(make_vertex(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
    endtask

    task automatic test_rounding_ties();
        // det = 2^17, so numerators 1, -1 and 3 land on exact halves.
        send_vertex(make_vertex(0, 0, 0, 0, 0));
        send_vertex(make_vertex(1, -1, 3, t_coord'(1) <<< 17, 0));
        send_vertex(make_vertex(0, 0, 0, 0, 1));
    endtask

    task automatic test_random_triangles(input int unsigned count);
        t_vertex     a, b, c;
        int unsigned kind;
        for (int unsigned t = 0; t < count; t++) begin
            kind = $urandom_range(7);
            a    = random_vertex(kind > 3 ? 3 : kind);
            b    = random_vertex(kind > 3 ? 3 : kind);
            c    = random_vertex(kind > 3 ? 3 : kind);
            if ($urandom_range(9) == 0) begin
                // Collapse the texture triangle onto a point or a line.
                b.tex_u = a.tex_u;
                b.tex_v = a.tex_v;
                if ($urandom_range(1)) begin
                    c.tex_u = a.tex_u;
                    c.tex_v = a.tex_v;
                end
            end
            send_vertex(a);
            send_vertex(b);
            send_vertex(c);
        end
    endtask

    always @(posedge i_clk) begin : tangent_check
        t_tangent got;
        t_tangent want;
        if (i_rst_n && tan.valid && tan.ready) begin
            got = '{tan.tangent_x, tan.tangent_y, tan.tangent_z,
                    tan.degenerate, tan.last_corner};
            if (expected_tangents.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected tangent word: x=%h y=%h z=%h degen=%b last=%b",
                             got.tangent_x, got.tangent_y, got.tangent_z,
                             got.degenerate, got.last_corner);
            end else begin
                want = expected_tangents.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"tangent mismatch: exp x=%h y=%h z=%h degen=%b last=%b,",
                                  " got x=%h y=%h z=%h degen=%b last=%b"},
                                 want.tangent_x, want.tangent_y, want.tangent_z,
                                 want.degenerate, want.last_corner,
                                 got.tangent_x, got.tangent_y, got.tangent_z,
                                 got.degenerate, got.last_corner);
                end
            end
        end
        if (!i_rst_n)
            tan.ready <= 1'b0;
        else
            tan.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    initial begin
        #10ms;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        i_rst_n   <= 1'b0;
        vtx.valid <= 1'b0;
        vtx.pos_x <= '0;
        vtx.pos_y <= '0;
        vtx.pos_z <= '0;
        vtx.tex_u <= '0;
        vtx.tex_v <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        source_idle_pct = 16;
        sink_idle_pct   = 86;
        test_unit_triangle();
        test_degenerate_uv();
        test_saturation_and_extremes();
        test_rounding_ties();
        test_random_triangles(TRI_PER_PHASE);

        source_idle_pct = 86;
        sink_idle_pct   = 16;
        test_random_triangles(TRI_PER_PHASE);

        source_idle_pct = 0;
        sink_idle_pct   = 0;
        test_random_triangles(TRI_PER_PHASE);

        vtx.valid <= 1'b0;
        while (expected_tangents.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
